### src/lru_key_value_cache_top_macros.svh
// Assertion macros shared by the cache checker.
// Needs signals clk and arst_n in the scope where a macro is used.
`ifndef LRU_KEY_VALUE_CACHE_TOP_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_TOP_MACROS_SVH

// Same-cycle implication, masked during reset
`define LKVC_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("cache port check failed");

// Next-cycle implication, masked during reset
`define LKVC_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("cache port check failed");

`endif

### src/lkvc_pkg.sv
// Shared types and constants for the LRU key/value cache.
// No dependencies; imported by the controller, datapath, top level and checker.
package lkvc_pkg;

	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// operation codes
	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;   // capture the accepted item, clear the sweep results
		logic rd_en;  // read one RAM entry
		logic eval;   // RAM data for eval_idx is on the read port
		logic commit; // update the tables and issue the result
	} lkvc_cmd_t;

endpackage

### src/lkvc_ram.sv
// Generic simple dual-port RAM with registered read data.
// No dependencies.
module lkvc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/lkvc_ctrl.sv
// Controller for the LRU cache: item acceptance, RAM sweep sequencing, commit.
// Depends on lkvc_pkg for the command struct.
module lkvc_ctrl #(
	parameter int MAX_ENTRIES = 16,
	localparam int IW = $clog2(MAX_ENTRIES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output lkvc_pkg::lkvc_cmd_t cmd,
	output logic [IW-1:0]       rd_idx,
	output logic [IW-1:0]       eval_idx
);
	import lkvc_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_WAIT   = 2'd2;
	localparam logic [1:0] ST_COMMIT = 2'd3;

	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);

	logic [1:0]    state_q;
	logic [1:0]    state_nxt;
	logic [IW-1:0] rd_q;
	logic          eval_s1;
	logic [IW-1:0] eval_idx_s1;

	// decode commands from the state
	always_comb begin
		cmd.load   = (state_q == ST_IDLE) && start;
		cmd.rd_en  = (state_q == ST_SCAN);
		cmd.eval   = eval_s1;
		cmd.commit = (state_q == ST_COMMIT);
	end

	assign busy     = (state_q != ST_IDLE);
	assign rd_idx   = rd_q;
	assign eval_idx = eval_idx_s1;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (rd_q == LAST_IDX) begin
					state_nxt = ST_WAIT;
				end
			end
			ST_WAIT:   state_nxt = ST_COMMIT;
			ST_COMMIT: state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// state, sweep counter and the read-to-evaluate stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_q        <= '0;
			eval_s1     <= 1'b0;
			eval_idx_s1 <= '0;
		end else begin
			state_q     <= state_nxt;
			eval_s1     <= cmd.rd_en;
			eval_idx_s1 <= rd_q;
			if (cmd.load) begin
				rd_q <= '0;
			end else if (cmd.rd_en) begin
				rd_q <= rd_q + IW'(1);
			end
		end
	end

endmodule

### src/lkvc_dp.sv
// Datapath for the LRU cache: key/value RAM, valid bits, recency ranks, result.
// Depends on lkvc_pkg and lkvc_ram.
module lkvc_dp #(
	parameter int MAX_ENTRIES = 16,
	localparam int IW = $clog2(MAX_ENTRIES)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lkvc_pkg::lkvc_cmd_t            cmd,
	input  logic [IW-1:0]                  rd_idx,
	input  logic [IW-1:0]                  eval_idx,
	input  logic                           opcode,
	input  logic [lkvc_pkg::KEY_W-1:0]     lookup_key,
	input  logic [lkvc_pkg::VAL_W-1:0]     write_value,
	input  logic                           cfg_valid,
	input  logic [lkvc_pkg::CAP_W-1:0]     cfg_data,
	output logic                           done,
	output logic                           hit,
	output logic [lkvc_pkg::VAL_W-1:0]     read_value
);
	import lkvc_pkg::*;

	localparam int RW = IW;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int EW = (CW > CAP_W) ? CW : CAP_W;
	localparam int DW = KEY_W + VAL_W;

	// configuration
	logic [CAP_W-1:0] cap_q;

	// accepted item
	logic             op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;

	// table state
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [RW-1:0]          rank_q [MAX_ENTRIES];
	logic [CW-1:0]          count_q;

	// sweep results
	logic             match_found_q;
	logic [IW-1:0]    match_idx_q;
	logic [RW-1:0]    match_rank_q;
	logic [VAL_W-1:0] match_data_q;
	logic             free_found_q;
	logic [IW-1:0]    free_idx_q;
	logic [IW-1:0]    oldest_idx_q;

	// result registers
	logic             done_q;
	logic             hit_q;
	logic [VAL_W-1:0] rdval_q;

	// RAM signals
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [DW-1:0] ram_wdata;
	logic [DW-1:0] ram_rdata;
	logic [KEY_W-1:0] ram_key;
	logic [VAL_W-1:0] ram_val;

	logic [EW-1:0] cap_eff;
	logic          evict;
	logic [IW-1:0] slot;
	logic [CW-1:0] count_m1;
	logic          lane_valid;
	logic          lane_oldest;

	assign ram_key = ram_rdata[DW-1:VAL_W];
	assign ram_val = ram_rdata[VAL_W-1:0];

	// clamp the capacity to one..MAX_ENTRIES
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = EW'(1);
		end else if (EW'(cap_q) > EW'(MAX_ENTRIES)) begin
			cap_eff = EW'(MAX_ENTRIES);
		end else begin
			cap_eff = EW'(cap_q);
		end
	end

	// pick the insertion slot: the least recent when full, else the first free
	assign evict    = (EW'(count_q) >= cap_eff);
	assign slot     = evict ? oldest_idx_q : free_idx_q;
	assign count_m1 = count_q - CW'(1);

	// the least recent valid entry carries rank count-1
	assign lane_valid  = valid_q[eval_idx];
	assign lane_oldest = lane_valid && (rank_q[eval_idx] == count_m1[RW-1:0]);

	// write back on a put, at the matching entry or the chosen slot
	assign ram_we    = cmd.commit && (op_q == OP_PUT);
	assign ram_waddr = match_found_q ? match_idx_q : slot;
	assign ram_wdata = {key_q, val_q};

	lkvc_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (rd_idx),
		.rdata (ram_rdata)
	);

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	// capture the item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode;
			key_q <= lookup_key;
			val_q <= write_value;
		end
	end

	// sweep flags: clear on load, set on the first hit or free entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
		end else if (cmd.load) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
		end else if (cmd.eval) begin
			if (lane_valid && !match_found_q && (ram_key == key_q)) begin
				match_found_q <= 1'b1;
			end
			if (!lane_valid) begin
				free_found_q <= 1'b1;
			end
		end
	end

	// sweep payload: the matching entry, the first free slot, the oldest slot
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			if (lane_valid && !match_found_q && (ram_key == key_q)) begin
				match_idx_q  <= eval_idx;
				match_rank_q <= rank_q[eval_idx];
				match_data_q <= ram_val;
			end
			if (!lane_valid && !free_found_q) begin
				free_idx_q <= eval_idx;
			end
			if (lane_oldest) begin
				oldest_idx_q <= eval_idx;
			end
		end
	end

	// update valid bits, ranks and occupancy on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			if (match_found_q) begin
				// promote: age the entries that were more recent than the match
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (valid_q[i] && (IW'(i) != match_idx_q) &&
					    (rank_q[i] < match_rank_q)) begin
						rank_q[i] <= rank_q[i] + RW'(1);
					end
				end
				rank_q[match_idx_q] <= '0;
			end else if (op_q == OP_PUT) begin
				// insert: age every surviving entry, new entry becomes most recent
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (valid_q[i] && !(evict && (IW'(i) == oldest_idx_q))) begin
						rank_q[i] <= rank_q[i] + RW'(1);
					end
				end
				rank_q[slot]  <= '0;
				valid_q[slot] <= 1'b1;
				if (!evict) begin
					count_q <= count_q + CW'(1);
				end
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.commit;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q   <= match_found_q;
			rdval_q <= (match_found_q && (op_q == OP_GET)) ? match_data_q : '0;
		end
	end

	assign done       = done_q;
	assign hit        = hit_q;
	assign read_value = rdval_q;

endmodule

### src/lru_key_value_cache_top.sv
// Fully associative key/value cache with least-recently-used replacement.
// An item is taken when start is high and busy is low. Each item sweeps the
// key/value RAM one entry per cycle, then passes a wait and a commit state,
// and the result is registered onto hit and read_value with the done strobe;
// busy drops in the strobe cycle, so a new item may be started then, but not
// before the block is through with the last one. The RAM sweep sets the
// pace. done lasts one cycle and cannot be held off: sample it then.
// capacity_in_use is written on cfg_data with cfg_valid (cfg_ready is always
// high); the user must write it only while no item is in flight (unenforced);
// zero reads as one, values above MAX_ENTRIES as MAX_ENTRIES. Reset needs no
// clearing pass. Depends on lkvc_pkg, lkvc_ctrl, lkvc_dp and lkvc_ram.
module lru_key_value_cache_top #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       opcode,
	input  logic [lkvc_pkg::KEY_W-1:0] lookup_key,
	input  logic [lkvc_pkg::VAL_W-1:0] write_value,
	output logic                       done,
	output logic                       hit,
	output logic [lkvc_pkg::VAL_W-1:0] read_value,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [lkvc_pkg::CAP_W-1:0] cfg_data
);
	import lkvc_pkg::*;

	localparam int IW = $clog2(MAX_ENTRIES);

	lkvc_cmd_t     cmd;
	logic [IW-1:0] rd_idx;
	logic [IW-1:0] eval_idx;

	// the capacity register takes a write in any cycle
	assign cfg_ready = 1'b1;

	lkvc_ctrl #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.rd_idx   (rd_idx),
		.eval_idx (eval_idx)
	);

	lkvc_dp #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.rd_idx      (rd_idx),
		.eval_idx    (eval_idx),
		.opcode      (opcode),
		.lookup_key  (lookup_key),
		.write_value (write_value),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.done        (done),
		.hit         (hit),
		.read_value  (read_value)
	);

endmodule

### src/lkvc_checker.sv
// Port-level checks for the LRU cache, bound to the top level.
// Depends on lkvc_pkg and the assertion macros header.
`include "lru_key_value_cache_top_macros.svh"

module lkvc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input logic                       hit,
	input logic [lkvc_pkg::VAL_W-1:0] read_value
);
	import lkvc_pkg::*;

	// an accepted item makes the block busy
	`LKVC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	// the strobe comes once the block has finished with the item
	`LKVC_ASSERT_NOW(a_done_idle, done, !busy)
	// one strobe per item, never two in a row
	`LKVC_ASSERT_NEXT(a_done_single, done, !done)
	// a miss returns zero data
	`LKVC_ASSERT_NOW(a_miss_zero, done && !hit, read_value == '0)

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.hit        (hit),
	.read_value (read_value)
);

### tb/lru_key_value_cache_top_tb.sv
// Self-checking bench for the LRU key/value cache: directed and random get/put
// items under several capacities, checked against an in-bench LRU predictor.
// Depends on lkvc_pkg and lru_key_value_cache_top.
module lru_key_value_cache_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lkvc_pkg::*;

	localparam int SLOTS       = 16;
	localparam int LATENCY     = SLOTS + 3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 75;

	typedef struct packed {
		logic             op;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] val;
	} access_t;

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] value;
	} reply_t;

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             start       = 1'b0;
	logic             opcode      = OP_GET;
	logic [KEY_W-1:0] lookup_key  = '0;
	logic [VAL_W-1:0] write_value = '0;
	logic             cfg_valid   = 1'b0;
	logic [CAP_W-1:0] cfg_data    = '0;
	logic             busy;
	logic             done;
	logic             hit;
	logic [VAL_W-1:0] read_value;
	logic             cfg_ready;

	// cache contents as the predictor sees them
	logic             slot_valid [SLOTS];
	logic [KEY_W-1:0] slot_key   [SLOTS];
	logic [VAL_W-1:0] slot_data  [SLOTS];
	int unsigned      slot_age   [SLOTS];
	logic [CAP_W-1:0] capacity;

	access_t access_q [$];
	reply_t  reply_q  [$];
	access_t cur_access;
	logic    loaded;
	logic    offer;
	logic    no_gaps;
	int      hold_off;
	reply_t  want;
	int      fail_count;
	int      cycle_count = 0;

	lru_key_value_cache_top #(
		.MAX_ENTRIES(SLOTS)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.lookup_key (lookup_key),
		.write_value(write_value),
		.done       (done),
		.hit        (hit),
		.read_value (read_value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Apply one access to the predicted cache and return the reply it gives
	function automatic reply_t lru_access(input access_t a);
		int i, match, free_slot, oldest, used, limit, s;
		int unsigned oldest_age, old_age;
		reply_t r;
		match = -1;
		free_slot = -1;
		oldest = -1;
		used = 0;
		oldest_age = 0;
		limit = int'(capacity);
		if (limit < 1) limit = 1;
		if (limit > SLOTS) limit = SLOTS;
		for (i = 0; i < SLOTS; i++) begin
			if (slot_valid[i]) begin
				used++;
				if (match < 0 && slot_key[i] == a.key) match = i;
				if (oldest < 0 || slot_age[i] > oldest_age) begin
					oldest = i;
					oldest_age = slot_age[i];
				end
			end else if (free_slot < 0) begin
				free_slot = i;
			end
		end
		r.hit = (match >= 0);
		r.value = '0;
		if (match >= 0) begin
			if (a.op == OP_GET) r.value = slot_data[match];
			else slot_data[match] = a.val;
			// age everything that was more recent than the hit slot
			old_age = slot_age[match];
			for (i = 0; i < SLOTS; i++)
				if (slot_valid[i] && i != match && slot_age[i] < old_age) slot_age[i]++;
			slot_age[match] = 0;
		end else if (a.op == OP_PUT) begin
			// evict the least recent slot once the capacity is reached
			if (used >= limit && oldest >= 0) begin
				slot_valid[oldest] = 1'b0;
				s = oldest;
			end else begin
				s = free_slot;
			end
			if (s >= 0) begin
				for (i = 0; i < SLOTS; i++)
					if (slot_valid[i]) slot_age[i]++;
				slot_valid[s] = 1'b1;
				slot_key[s] = a.key;
				slot_data[s] = a.val;
				slot_age[s] = 0;
			end
		end
		return r;
	endfunction

	// Feed items from the queue, each after a random hold-off, at times back to back
	always @(posedge clk) begin
		if (arst_n) begin
			offer = start && busy;
			if (start && !busy) begin
				reply_q.push_back(lru_access(cur_access));
				loaded = 1'b0;
			end
			if (!loaded && access_q.size() != 0) begin
				cur_access = access_q.pop_front();
				if ($urandom_range(0, 31) == 0) no_gaps = !no_gaps;
				hold_off = no_gaps ? 0 : $urandom_range(0, 15);
				loaded = 1'b1;
			end
			if (loaded && !offer) begin
				if (hold_off == 0) offer = 1'b1;
				else hold_off--;
			end
			start <= offer;
			opcode <= cur_access.op;
			lookup_key <= cur_access.key;
			write_value <= cur_access.val;
		end
	end

	// Compare every strobed result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (reply_q.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, got hit %0b value %h",
					$time, hit, read_value);
				fail_count++;
			end else begin
				want = reply_q.pop_front();
				if (hit !== want.hit) begin
					$display("%0t ns: hit expected %0b, got %0b", $time, want.hit, hit);
					fail_count++;
				end
				if (read_value !== want.value) begin
					$display("%0t ns: read_value expected %h, got %h",
						$time, want.value, read_value);
					fail_count++;
				end
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic queue_access(input logic op, input logic [KEY_W-1:0] key,
		input logic [VAL_W-1:0] val);
		access_t a;
		a.op = op;
		a.key = key;
		a.val = val;
		access_q.push_back(a);
	endtask

	// Random content, extremes now and then
	function automatic logic [31:0] draw_word();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Queue a random phase over a small key pool so that hits and evictions occur
	task automatic queue_random(input int count, input int pool_size);
		logic [KEY_W-1:0] pool [$];
		logic [KEY_W-1:0] base;
		int pick;
		base = draw_word();
		pool.push_back(base);
		while (pool.size() < pool_size) begin
			// keys one bit apart stress the comparators
			if ($urandom_range(0, 1)) pool.push_back(base ^ (32'd1 << $urandom_range(0, 31)));
			else pool.push_back(draw_word());
		end
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				queue_access(OP_GET, pool[$urandom_range(0, pool.size() - 1)], draw_word());
			else if (pick < 85)
				queue_access(OP_PUT, pool[$urandom_range(0, pool.size() - 1)], draw_word());
			else
				queue_access(1'($urandom_range(0, 1)), $urandom, $urandom);
		end
	endtask

	// Hold until every item has been sent and every result has arrived
	task automatic wait_idle();
		@(posedge clk);
		while (access_q.size() != 0 || loaded || start || reply_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] v);
		@(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		capacity = v;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int ph, eff;
		logic [CAP_W-1:0] cap;
		for (int i = 0; i < SLOTS; i++) begin
			slot_valid[i] = 1'b0;
			slot_key[i] = '0;
			slot_data[i] = '0;
			slot_age[i] = 0;
		end
		capacity = CAP_RESET;
		cur_access = '0;
		loaded = 1'b0;
		no_gaps = 1'b0;
		hold_off = 0;
		fail_count = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty miss, extreme keys and values, update, fill and evict
		queue_access(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
		queue_access(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
		queue_access(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
		queue_access(OP_GET, 32'h0000_0000, 32'h0000_0000);
		queue_access(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		queue_access(OP_PUT, 32'h0000_0000, 32'hA5A5_5A5A);
		queue_access(OP_GET, 32'h0000_0000, 32'h0000_0000);
		queue_access(OP_GET, 32'h0000_0001, 32'h0000_0000);
		for (int k = 1; k <= SLOTS - 2; k++) queue_access(OP_PUT, k, $urandom);
		queue_access(OP_PUT, 32'h8000_0000, 32'h1234_5678);
		queue_access(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		queue_access(OP_GET, 32'h0000_0000, 32'h0000_0000);
		wait_idle();

		// random phases; the first lowers the capacity below a full cache
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: cap = 5'd3;
				1: cap = 5'd0;
				2: cap = 5'd31;
				3: cap = 5'd1;
				4: cap = 5'd16;
				5: cap = 5'd2;
				default: cap = CAP_W'($urandom_range(0, 31));
			endcase
			set_capacity(cap);
			eff = (cap == 0) ? 1 : (int'(cap) > SLOTS) ? SLOTS : int'(cap);
			queue_random(PHASE_ITEMS, eff + $urandom_range(1, 6));
			wait_idle();
		end

		// let any stray result show up
		repeat (2 * LATENCY) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
